>>> hdl/rkbd_pkg.sv
// Package for the rotary knob and button decoder.
// Holds the word types, the register indexes and the quadrature phase table.
// No dependencies.
package rkbd_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned NumBtn   = 3;

  localparam logic [CfgW-1:0] DetentsReset  = 8'd1;
  localparam logic [CfgW-1:0] DebounceReset = 8'd20;

  typedef enum logic [1:0] {
    REG_DETENTS  = 2'd0,
    REG_DEBOUNCE = 2'd1,
    REG_SPARE2   = 2'd2,
    REG_SPARE3   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_REST      = 3'd0,
    PH_CW_LAST   = 3'd1,
    PH_CW_START  = 3'd2,
    PH_CW_CONT   = 3'd3,
    PH_CCW_START = 3'd4,
    PH_CCW_LAST  = 3'd5,
    PH_CCW_CONT  = 3'd6
  } phase_e;

  localparam logic signed [1:0] RotNone = 2'sd0;
  localparam logic signed [1:0] RotCw   = -2'sd1;
  localparam logic signed [1:0] RotCcw  = 2'sd1;

  typedef struct packed {
    logic              chan_a;
    logic              chan_b;
    logic              eject_level;
    logic              insert_level;
    logic              knob_level;
    logic [TimeW-1:0]  time_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [1:0] rotation;
    logic              eject_pressed;
    logic              insert_pressed;
    logic              knob_pressed;
  } out_word_t;

  typedef struct packed {
    phase_e phase;
    logic   cw;
    logic   ccw;
  } phase_step_t;

  // Full-step table; column is {chan_b, chan_a}. The unused code steps as rest.
  function automatic phase_step_t phase_next(input phase_e cur, input logic [1:0] col);
    phase_step_t r;
    r = '{phase: PH_REST, cw: 1'b0, ccw: 1'b0};
    case (cur)
      PH_CW_LAST: begin
        case (col)
          2'd0:    r.phase = PH_CW_CONT;
          2'd1:    r.phase = PH_REST;
          2'd2:    r.phase = PH_CW_LAST;
          default: r.cw    = 1'b1;
        endcase
      end
      PH_CW_START: begin
        case (col)
          2'd0:    r.phase = PH_CW_CONT;
          2'd1:    r.phase = PH_CW_START;
          default: r.phase = PH_REST;
        endcase
      end
      PH_CW_CONT: begin
        case (col)
          2'd0:    r.phase = PH_CW_CONT;
          2'd1:    r.phase = PH_CW_START;
          2'd2:    r.phase = PH_CW_LAST;
          default: r.phase = PH_REST;
        endcase
      end
      PH_CCW_START: begin
        case (col)
          2'd0:    r.phase = PH_CCW_CONT;
          2'd2:    r.phase = PH_CCW_START;
          default: r.phase = PH_REST;
        endcase
      end
      PH_CCW_LAST: begin
        case (col)
          2'd0:    r.phase = PH_CCW_CONT;
          2'd1:    r.phase = PH_CCW_LAST;
          2'd2:    r.phase = PH_REST;
          default: r.ccw   = 1'b1;
        endcase
      end
      PH_CCW_CONT: begin
        case (col)
          2'd0:    r.phase = PH_CCW_CONT;
          2'd1:    r.phase = PH_CCW_LAST;
          2'd2:    r.phase = PH_CCW_START;
          default: r.phase = PH_REST;
        endcase
      end
      default: begin
        case (col)
          2'd1:    r.phase = PH_CW_START;
          2'd2:    r.phase = PH_CCW_START;
          default: r.phase = PH_REST;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

>>> hdl/rotary_knob_and_button_decoder.sv
// Rotary knob and button decoder, top level.
// Depends on rkbd_pkg.
//
// Takes one poll word per cycle and gives one result word per poll in the cycle
// after acceptance. The phase table lookup, the detent counter and the three
// 32-bit hold-time compares all sit between the state registers and a single
// output register, so a word is accepted every cycle unless a result is
// waiting and the output side stalls. Rotation is -1 clockwise, +1
// counter-clockwise; a button press is reported on release after a hold
// strictly longer than debounce_ms. The user must write registers through cfg_we_i
// only while the block is idle, unguarded by the block; indexes 2 and 3 are ignored.
module rotary_knob_and_button_decoder
  import rkbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o
);

  logic [CfgW-1:0]  detents_q, debounce_q;
  phase_e           phase_q, phase_d;
  logic [7:0]       count_q, count_d;
  logic             last_cw_q, last_cw_d;
  logic [TimeW-1:0] since_q [NumBtn];
  logic [TimeW-1:0] since_d [NumBtn];
  logic [NumBtn-1:0] level, press;
  logic             out_valid_q;
  out_word_t        out_word_q, out_word_d;
  logic             accept;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign level = {in_word_i.knob_level, in_word_i.insert_level, in_word_i.eject_level};

  // buttons: timestamp of press, zero means not held
  always_comb begin
    logic [TimeW-1:0] held;
    for (int i = 0; i < NumBtn; i++) begin
      held = in_word_i.time_ms - since_q[i];
      if (level[i]) begin
        since_d[i] = (since_q[i] == '0) ? in_word_i.time_ms : since_q[i];
        press[i]   = 1'b0;
      end else begin
        since_d[i] = '0;
        press[i]   = (since_q[i] != '0) && (held > {{(TimeW-CfgW){1'b0}}, debounce_q});
      end
    end
  end

  always_comb begin
    phase_step_t      st;
    logic [7:0]       lim;
    logic signed [1:0] rot;
    st        = phase_next(phase_q, {in_word_i.chan_b, in_word_i.chan_a});
    lim       = (detents_q == '0) ? '0 : detents_q - 8'd1;
    rot       = RotNone;
    phase_d   = st.phase;
    count_d   = count_q;
    last_cw_d = last_cw_q;
    if (st.cw || st.ccw) begin
      if (st.cw == last_cw_q) begin
        if (count_q < lim) begin
          count_d = count_q + 8'd1;
        end else begin
          rot     = st.cw ? RotCw : RotCcw;
          count_d = '0;
        end
      end else begin
        // reversal restarts the count at one
        count_d   = 8'd1;
        last_cw_d = st.cw;
        if (lim == '0) begin
          rot = st.cw ? RotCw : RotCcw;
        end
      end
    end
    out_word_d.rotation       = rot;
    out_word_d.eject_pressed  = press[0];
    out_word_d.insert_pressed = press[1];
    out_word_d.knob_pressed   = press[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detents_q  <= DetentsReset;
      debounce_q <= DebounceReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DETENTS:  detents_q  <= cfg_data_i;
        REG_DEBOUNCE: debounce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_REST;
      count_q   <= '0;
      last_cw_q <= 1'b1;
      for (int i = 0; i < NumBtn; i++) begin
        since_q[i] <= '0;
      end
    end else if (accept) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      last_cw_q <= last_cw_d;
      for (int i = 0; i < NumBtn; i++) begin
        since_q[i] <= since_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

>>> hdl/rkbd_checker.sv
// Port-level checker for the rotary knob and button decoder, with its bind.
// Depends on rkbd_pkg and rotary_knob_and_button_decoder.
module rkbd_checker
  import rkbd_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input in_word_t        in_word_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input out_word_t       out_word_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // every accepted poll produces a result next cycle
  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted poll gave no result");

  a_rot_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.rotation != 2'b10)
    else $error("illegal rotation code");

  // the eject button, while still held, cannot report a press
  a_held_no_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.eject_level |=> !out_word_o.eject_pressed)
    else $error("press reported while button held");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

endmodule

bind rotary_knob_and_button_decoder rkbd_checker u_rkbd_checker (.*);
